// ----- src/vhm_pkg.sv -----
// Package: widths, heading constants and CORDIC step-angle table for vector_heading_millidegree.
package vhm_pkg;

    localparam int COORD_BITS_DEF   = 32;
    localparam int CORDIC_STEPS_DEF = 32;

    localparam int FW     = 32;
    localparam int IN_TW  = 4 * FW;
    localparam int HW     = 20;
    localparam int OUT_TW = 24;

    localparam int DW       = 64;
    localparam int MAG_TOP  = 60;
    localparam int ZF       = 20;
    localparam int ZW       = ZF + HW;

    localparam int XF_LSB = 0;
    localparam int YF_LSB = FW;
    localparam int XT_LSB = 2 * FW;
    localparam int YT_LSB = 3 * FW;

    localparam logic [HW-1:0] MDEG_90  = HW'(90000);
    localparam logic [HW-1:0] MDEG_180 = HW'(180000);
    localparam logic [HW-1:0] MDEG_270 = HW'(270000);
    localparam logic [HW-1:0] MAG_MAX  = HW'(89999);

    localparam logic [63:0] K44 = 64'd1007958012753982965;

    function automatic logic [63:0] odd_div(input logic [63:0] a, input int unsigned k);
        logic [63:0] q;
        case (k)
            0:  q = a;          1:  q = a / 64'd3;  2:  q = a / 64'd5;  3:  q = a / 64'd7;
            4:  q = a / 64'd9;  5:  q = a / 64'd11; 6:  q = a / 64'd13; 7:  q = a / 64'd15;
            8:  q = a / 64'd17; 9:  q = a / 64'd19; 10: q = a / 64'd21; 11: q = a / 64'd23;
            12: q = a / 64'd25; 13: q = a / 64'd27; 14: q = a / 64'd29; 15: q = a / 64'd31;
            16: q = a / 64'd33; 17: q = a / 64'd35; 18: q = a / 64'd37; 19: q = a / 64'd39;
            20: q = a / 64'd41; 21: q = a / 64'd43; 22: q = a / 64'd45; 23: q = a / 64'd47;
            24: q = a / 64'd49; 25: q = a / 64'd51; 26: q = a / 64'd53; 27: q = a / 64'd55;
            28: q = a / 64'd57; 29: q = a / 64'd59; 30: q = a / 64'd61; 31: q = a / 64'd63;
            default: q = '0;
        endcase
        return q;
    endfunction

    // atan(2^-i) in 2^-20 millidegree, from the arctangent series at 2^-44, rounded at 2^-24
    function automatic logic signed [ZW-1:0] step_angle(input int unsigned i);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [63:0]  rnd;
        int unsigned  sh;
        sum = '0;
        if (i == 0) begin
            return ZW'(64'd45000 << ZF);
        end
        for (int unsigned k = 0; k < 32; k++) begin
            sh = i * (2 * k + 1);
            if (sh < 64) begin
                term = odd_div(K44 >> sh, k);
                if (k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        rnd = (sum + (64'd1 << 23)) >> 24;
        return rnd[ZW-1:0];
    endfunction

endpackage

// ----- src/vector_heading_millidegree.sv -----
// Top level: pipelined CORDIC vectoring heading unit, point pair in, millidegrees out.
//
// Input stream (s_axis): one transaction carries x_from, y_from, x_to, y_to.
// Output stream (m_axis): one transaction per input carrying the heading,
// screen convention (y down), range -89999..270000 millidegrees.
// Stages: one for differences and magnitudes, one per CORDIC micro-rotation,
// and one for the angle fold-out.
// Throughput: one transaction per cycle unless the receiver stalls; each
// micro-rotation owns its own adders and register stage, so items follow each
// other with no gaps. Vertical vectors are detected in the first stage and ride
// down the pipe as flags alongside the datapath.
// Reset clears all valid bits; the payload registers are not reset.
// When the receiver stalls with a result held in the output register, the
// whole pipe holds in place and o_s_axis_tready drops; nothing is lost or
// repeated. While the output register is empty the pipe always advances.
module vector_heading_millidegree
    import vhm_pkg::*;
#(
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [IN_TW-1:0]  i_s_axis_tdata,  // x_from, y_from, x_to, y_to (32 each)
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [OUT_TW-1:0] o_m_axis_tdata   // heading (20, signed), 4 zero bits
);

    localparam int CW        = COORD_BITS + 1;
    localparam int PRE_SHIFT = MAG_TOP - COORD_BITS;

    typedef struct packed {
        logic dx_zero;
        logic dx_neg;
        logic dy_zero;
        logic dy_neg;
    } t_side;

    logic signed [DW-1:0] r_x [0:CORDIC_STEPS];
    logic signed [DW-1:0] r_y [0:CORDIC_STEPS];
    logic signed [ZW-1:0] r_z [0:CORDIC_STEPS];
    t_side                r_f [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] r_v;
    logic                 r_out_v;
    logic [HW-1:0]        r_out_h;

    logic          w_en;
    logic          w_in_fire;
    logic [CW-1:0] w_xf, w_yf, w_xt, w_yt;
    logic [CW-1:0] w_dx, w_dy, w_ax, w_ay;
    t_side         w_side;

    logic [HW-1:0]        w_mag;
    logic signed [HW:0]   w_a;
    logic signed [HW:0]   w_res;
    logic [HW-1:0]        n_out_h;
    t_side                w_fl;
    logic signed [ZW-1:0] w_z;

    assign w_en            = !r_out_v || i_m_axis_tready;
    assign w_in_fire       = i_s_axis_tvalid && w_en;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {(OUT_TW - HW)'(0), r_out_h};

    // differences are exact at COORD_BITS+1 bits
    assign w_xf = {i_s_axis_tdata[XF_LSB+COORD_BITS-1], i_s_axis_tdata[XF_LSB +: COORD_BITS]};
    assign w_yf = {i_s_axis_tdata[YF_LSB+COORD_BITS-1], i_s_axis_tdata[YF_LSB +: COORD_BITS]};
    assign w_xt = {i_s_axis_tdata[XT_LSB+COORD_BITS-1], i_s_axis_tdata[XT_LSB +: COORD_BITS]};
    assign w_yt = {i_s_axis_tdata[YT_LSB+COORD_BITS-1], i_s_axis_tdata[YT_LSB +: COORD_BITS]};
    assign w_dx = w_xt - w_xf;
    assign w_dy = w_yt - w_yf;
    assign w_ax = w_dx[CW-1] ? (~w_dx + 1'b1) : w_dx;
    assign w_ay = w_dy[CW-1] ? (~w_dy + 1'b1) : w_dy;

    always_comb begin
        w_side.dx_zero = (w_dx == '0);
        w_side.dx_neg  = w_dx[CW-1];
        w_side.dy_zero = (w_dy == '0);
        w_side.dy_neg  = w_dy[CW-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0] <= DW'(w_ax) << PRE_SHIFT;
            r_y[0] <= DW'(w_ay) << PRE_SHIFT;
            r_z[0] <= '0;
            r_f[0] <= w_side;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam logic signed [ZW-1:0] ANG = step_angle(i);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r_y[i][DW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - ANG;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + ANG;
                end
                r_f[i+1] <= r_f[i];
            end
        end
    end

    assign w_z  = r_z[CORDIC_STEPS];
    assign w_fl = r_f[CORDIC_STEPS];

    always_comb begin
        if (w_z[ZW-1]) begin
            w_mag = '0;
        end else if (w_z[ZW-1:ZF] > MAG_MAX) begin
            w_mag = MAG_MAX;
        end else begin
            w_mag = w_z[ZW-1:ZF];
        end

        if (w_fl.dy_zero) begin
            w_a = '0;
        end else if (w_fl.dx_neg != w_fl.dy_neg) begin
            w_a = -$signed({1'b0, w_mag});
        end else begin
            w_a = $signed({1'b0, w_mag});
        end

        if (w_fl.dx_zero) begin
            w_res = (w_fl.dy_zero || w_fl.dy_neg) ? $signed({1'b0, MDEG_90})
                                                  : $signed({1'b0, MDEG_270});
        end else if (w_fl.dx_neg) begin
            w_res = $signed({1'b0, MDEG_180}) - w_a;
        end else begin
            w_res = -w_a;
        end
        n_out_h = w_res[HW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_v     <= {r_v[CORDIC_STEPS-1:0], w_in_fire};
            r_out_v <= r_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_h <= n_out_h;
        end
    end

endmodule

// ----- src/vhm_checker.sv -----
// Checker: port-level properties of vector_heading_millidegree, bound to the top level.
module vhm_checker
    import vhm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_s_axis_tready,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [OUT_TW-1:0] o_m_axis_tdata
);

    logic signed [HW-1:0] w_h;
    assign w_h = o_m_axis_tdata[HW-1:0];

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_h >= -20'sd89999) && (w_h <= 20'sd270000)
                            && (o_m_axis_tdata[OUT_TW-1:HW] == '0))
        else $error("heading out of range");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output register");

    a_ready_when_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input blocked while output is drained");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind vector_heading_millidegree vhm_checker u_vhm_checker (.*);

// ----- test/tb_vector_heading_millidegree.sv -----
// Testbench for vector_heading_millidegree: directed table, then random point pairs.
module tb_vector_heading_millidegree;
    timeunit 1ns;
    timeprecision 1ps;
    import vhm_pkg::*;

    localparam int LATENCY      = CORDIC_STEPS_DEF + 2;
    localparam int ALIGN_SHIFT  = 60 - COORD_BITS_DEF;
    localparam int HOLD_CYCLES  = 160;
    localparam int STALL_LIMIT  = 2000;
    localparam int N_RAND_PHASE = 200;
    localparam int MAX_REPORTS  = 10;
    localparam int CMAX         = 32'sh7fff_ffff;
    localparam int CMIN         = 32'sh8000_0000;
    localparam int N_DIR        = 25;

    // x_from in the lowest bits, y_to in the highest
    typedef struct packed {
        logic signed [31:0] yt;
        logic signed [31:0] xt;
        logic signed [31:0] yf;
        logic signed [31:0] xf;
    } t_pts;

    typedef struct {
        t_pts            p;
        logic [HW-1:0]   heading;
    } t_heading_exp;

    typedef struct {
        int            xf;
        int            yf;
        int            xt;
        int            yt;
        bit            typed;
        logic [HW-1:0] heading;
    } t_dir_row;

    // typed rows carry their heading; the rest go through the predictor
    t_dir_row dir_tab [N_DIR] = '{
        '{0, 0, 0, 0, 1'b1, MDEG_90},
        '{0, 0, 0, 5, 1'b1, MDEG_270},
        '{0, 5, 0, 0, 1'b1, MDEG_90},
        '{0, 0, 7, 0, 1'b1, '0},
        '{7, 0, 0, 0, 1'b1, MDEG_180},
        '{CMIN, 0, CMAX, 0, 1'b1, '0},
        '{CMAX, 0, CMIN, 0, 1'b1, MDEG_180},
        '{0, CMIN, 0, CMAX, 1'b1, MDEG_270},
        '{0, CMAX, 0, CMIN, 1'b1, MDEG_90},
        '{CMAX, CMAX, CMAX, CMAX, 1'b1, MDEG_90},
        '{CMIN, CMIN, CMIN, CMIN, 1'b1, MDEG_90},
        '{-1, -1, -1, -1, 1'b1, MDEG_90},
        '{0, 0, 100, 100, 1'b0, '0},
        '{0, 0, 100, -100, 1'b0, '0},
        '{0, 0, -100, 100, 1'b0, '0},
        '{0, 0, -100, -100, 1'b0, '0},
        '{0, CMIN, 1, CMAX, 1'b0, '0},
        '{1, CMIN, 0, CMAX, 1'b0, '0},
        '{0, CMAX, 1, CMIN, 1'b0, '0},
        '{1, CMAX, 0, CMIN, 1'b0, '0},
        '{CMIN, 0, CMAX, 1, 1'b0, '0},
        '{CMAX, CMAX, CMIN, CMIN, 1'b0, '0},
        '{CMIN, CMAX, CMAX, CMIN, 1'b0, '0},
        '{-1, 0, 0, -1, 1'b0, '0},
        '{3, 4, -12345, 98765, 1'b0, '0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [IN_TW-1:0]   in_data = '0;       // x_from, y_from, x_to, y_to
    logic               in_typed = 1'b0;
    logic [HW-1:0]      in_typed_heading = '0;
    logic               s_ready;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [OUT_TW-1:0]  out_data;           // heading (20, signed), 4 zero bits

    t_heading_exp heading_q [$];
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_err = 0;
    int n_vertical = 0;
    int n_horizontal = 0;
    int quiet = 0;
    int hold_left = 0;
    bit hold_tog = 1'b0;
    bit hold_seen = 1'b0;

    vector_heading_millidegree DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    always #6 clk = ~clk;

    // atan(2^-i) in 2^-20 millidegree
    function automatic longint micro_angle(input int i);
        longint unsigned k44;
        longint unsigned term;
        longint          sum;
        int              sh;
        k44 = 64'd1007958012753982965;
        sum = 0;
        if (i == 0) begin
            return longint'(45000) <<< 20;
        end
        for (int k = 0; k < 64; k++) begin
            sh = i * (2 * k + 1);
            if (sh >= 64) begin
                break;
            end
            term = (k44 >> sh) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
                sum -= longint'(term);
            end else begin
                sum += longint'(term);
            end
        end
        return (sum + (longint'(1) <<< 23)) >>> 24;
    endfunction

    function automatic logic [HW-1:0] heading_of(input t_pts p);
        longint dx;
        longint dy;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint mag;
        longint a;
        longint res;
        dx = longint'($signed(p.xt)) - longint'($signed(p.xf));
        dy = longint'($signed(p.yt)) - longint'($signed(p.yf));
        if (dx == 0) begin
            res = (dy > 0) ? 270000 : 90000;
        end else begin
            x = (dx < 0 ? -dx : dx) <<< ALIGN_SHIFT;
            y = (dy < 0 ? -dy : dy) <<< ALIGN_SHIFT;
            z = 0;
            for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x += ys;
                    y -= xs;
                    z += micro_angle(i);
                end else begin
                    x -= ys;
                    y += xs;
                    z -= micro_angle(i);
                end
            end
            mag = (z < 0) ? 0 : (z >>> 20);
            if (mag > 89999) begin
                mag = 89999;
            end
            if (dy == 0) begin
                a = 0;
            end else if ((dx < 0) != (dy < 0)) begin
                a = -mag;
            end else begin
                a = mag;
            end
            res = (dx > 0) ? -a : 180000 - a;
        end
        return res[HW-1:0];
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_pts random_pts();
        t_pts p;
        int   d;
        p.xf = $urandom;
        p.yf = $urandom;
        p.xt = $urandom;
        p.yt = $urandom;
        case ($urandom_range(10))
            4, 5: begin
                p.xt = p.xf + jitter(1000);
                p.yt = p.yf + jitter(1000);
            end
            6: begin
                p.xt = p.xf;
            end
            7: begin
                p.yt = p.yf;
            end
            8: begin
                d = jitter(1 << 20);
                p.xf = jitter(1 << 24);
                p.yf = jitter(1 << 24);
                p.xt = p.xf + d;
                p.yt = $urandom_range(1) ? p.yf + d : p.yf - d;
            end
            9: begin
                p.xt = p.xf + jitter(3);
            end
            10: begin
                p.yt = p.yf + jitter(3);
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    task automatic note_error(input string msg);
        n_err++;
        if (n_err <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic offer(input t_pts p, input bit typed, input logic [HW-1:0] hd);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        in_data          <= p;
        in_typed         <= typed;
        in_typed_heading <= hd;
        @(posedge clk);
        while (!s_ready) begin
            @(posedge clk);
        end
        n_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (n_results == n_sent);
        @(posedge clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk) begin : scoreboard
        t_heading_exp e;
        t_pts         p;
        if (rst_n) begin
            if (in_valid && s_ready) begin
                p = in_data;
                e.p = p;
                e.heading = in_typed ? in_typed_heading : heading_of(p);
                heading_q.push_back(e);
                if (p.xt == p.xf) begin
                    n_vertical++;
                end else if (p.yt == p.yf) begin
                    n_horizontal++;
                end
            end
            if (out_valid && out_ready) begin
                n_results++;
                if (heading_q.size() == 0) begin
                    note_error($sformatf("unexpected heading transaction, tdata %h", out_data));
                end else begin
                    e = heading_q.pop_front();
                    if (out_data[HW-1:0] !== e.heading || out_data[OUT_TW-1:HW] !== '0) begin
                        note_error($sformatf(
                            "mismatch (%0d,%0d)->(%0d,%0d): exp %0d, got %0d (tdata %h)",
                            e.p.xf, e.p.yf, e.p.xt, e.p.yt, $signed(e.heading),
                            $signed(out_data[HW-1:0]), out_data));
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && s_ready) || (out_valid && out_ready)) begin
                quiet <= 0;
            end else if (quiet == STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("tb_vector_heading_millidegree: done, errors");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin
        t_pts p;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 8;
        rcv_idle_pct <= 46;
        foreach (dir_tab[r]) begin
            p.xf = dir_tab[r].xf;
            p.yf = dir_tab[r].yf;
            p.xt = dir_tab[r].xt;
            p.yt = dir_tab[r].yt;
            offer(p, dir_tab[r].typed, dir_tab[r].heading);
        end
        repeat (N_RAND_PHASE) offer(random_pts(), 1'b0, '0);
        drain();

        snd_idle_pct = 46;
        rcv_idle_pct <= 8;
        repeat (N_RAND_PHASE) offer(random_pts(), 1'b0, '0);
        drain();

        // back-to-back traffic against a long output stall fills the pipe
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        hold_tog <= ~hold_tog;
        repeat (N_RAND_PHASE) offer(random_pts(), 1'b0, '0);
        drain();

        repeat (2 * LATENCY) @(posedge clk);
        if (heading_q.size() != 0) begin
            note_error($sformatf("%0d headings never came out", heading_q.size()));
        end
        $display("covered %0d point pairs, %0d of them from the directed table",
                 n_sent, N_DIR);
        $display("%0d vertical, %0d horizontal; %0d headings compared, %0d mismatches",
                 n_vertical, n_horizontal, n_results, n_err);
        if (n_err == 0) begin
            $display("tb_vector_heading_millidegree: done, clean");
        end else begin
            $display("tb_vector_heading_millidegree: done, errors");
        end
        $finish;
    end

endmodule
